@@ sv/scdc_pkg.sv @@
// shared types and constants for the size class distance culler
`default_nettype none

package scdc_pkg;

    localparam int TABLE_DEPTH = 8;
    localparam int COORD_WIDTH = 24;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam int FIELD_W = 16;
    localparam int ENTRY_INDEX_W = 3;
    localparam int ENTRY_COUNT_W = 4;
    localparam int IDX_CMP_W = (CNT_W > ENTRY_INDEX_W) ? CNT_W : ENTRY_INDEX_W;

    localparam int DIFF_W = ((COORD_WIDTH > FIELD_W) ? COORD_WIDTH : FIELD_W) + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int ACC_W = PROD_W + 2;
    localparam int LIM_SHIFT = 16;
    localparam int CMP_W = PROD_W + LIM_SHIFT;

    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_X = 3'd0;
    localparam logic [STEP_W-1:0] STEP_Y = 3'd1;
    localparam logic [STEP_W-1:0] STEP_Z = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DIST = 3'd3;
    localparam logic [STEP_W-1:0] STEP_LAST_SQ = 3'd4;
    localparam logic [STEP_W-1:0] STEP_CMP = 3'd5;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = COORD_WIDTH;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAMERA_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAMERA_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAMERA_Z = 2'd2;

    localparam int CMD_W = 2;
    localparam int STATUS_W = 2;

    localparam int OFS_RADIUS = 0;
    localparam int OFS_DIST = OFS_RADIUS + FIELD_W;
    localparam int OFS_INDEX = OFS_DIST + FIELD_W;
    localparam int OFS_X = OFS_INDEX + ENTRY_INDEX_W;
    localparam int OFS_Y = OFS_X + COORD_WIDTH;
    localparam int OFS_Z = OFS_Y + COORD_WIDTH;
    localparam int OFS_SIZE = OFS_Z + COORD_WIDTH;
    localparam int IN_BITS = OFS_SIZE + FIELD_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_BITS = 1 + STATUS_W + ENTRY_COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT,
        CMD_REMOVE_PAIR,
        CMD_REMOVE_INDEX,
        CMD_QUERY
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK,
        STAT_FULL,
        STAT_NO_MATCH,
        STAT_BAD_INDEX
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_WRITE,
        ST_MATH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [FIELD_W-1:0] radius;
        logic [FIELD_W-1:0] distance;
    } t_entry;

endpackage

`default_nettype wire

@@ sv/size_class_distance_culler_top.sv @@
// size class distance culler: table sequencer, shared squarer and result register
// insert scans, shifts the later entries up and writes; remove pair scans and, on a
// match, shifts; remove at index shifts; query scans and may then square and compare;
// a new item is taken only in idle, once the last result is in the output register;
// the table port moves one entry per cycle and one shared multiplier squares the
// three axis deltas and the cull distance in turn
// synchronous active-low reset empties the table and zeroes the camera position
`default_nettype none

module size_class_distance_culler_top (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire  [scdc_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  wire                                   i_cfg_we,
    input  wire  [scdc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // class_radius, class_distance, entry_index, object_x, object_y, object_z,
    // object_size, zero pad
    input  wire  [scdc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // command
    input  wire  [scdc_pkg::CMD_W-1:0]            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // visible, status, entry_count, zero pad
    output logic [scdc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import scdc_pkg::*;

    localparam logic [CNT_W-1:0] CNT_ONE = 1;
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(TABLE_DEPTH);

    t_state r_state, n_state;
    t_cmd r_cmd;
    t_status r_status;
    logic [FIELD_W-1:0] r_rad, r_dist, r_size;
    logic signed [COORD_WIDTH-1:0] r_obj_x, r_obj_y, r_obj_z;
    logic signed [COORD_WIDTH-1:0] r_cam_x, r_cam_y, r_cam_z;
    logic [CNT_W-1:0] r_used, r_ptr, r_pos, r_rd_idx;
    logic r_rd_vld, r_found, r_picked, r_vis;
    logic [FIELD_W-1:0] r_best_gap, r_best_dist;
    logic [STEP_W-1:0] r_step;
    logic [DIFF_W-1:0] r_opnd;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0] r_acc;
    logic r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    logic w_in_acc, w_out_free, w_full, w_bad_idx, w_scan_done, w_shift_done;
    logic w_is_insert, w_match;
    t_cmd w_in_cmd;
    logic [ENTRY_INDEX_W-1:0] w_in_idx;
    logic [FIELD_W-1:0] w_gap;
    logic w_mem_re, w_mem_we;
    logic [CNT_W-1:0] w_rd_src, w_wr_dst;
    t_entry w_wdata;
    logic signed [DIFF_W-1:0] w_sub_a, w_sub_b, w_diff;
    logic [DIFF_W-1:0] w_abs;
    logic [PROD_W-1:0] w_sq;
    logic [CMP_W-1:0] w_lim;

    assign w_in_cmd = t_cmd'(s_axis_tuser);
    assign w_in_idx = s_axis_tdata[OFS_INDEX +: ENTRY_INDEX_W];
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_full = r_used >= CNT_DEPTH;
    assign w_bad_idx = IDX_CMP_W'(w_in_idx) >= IDX_CMP_W'(r_used);
    assign w_is_insert = r_cmd == CMD_INSERT;
    assign w_scan_done = (r_ptr == r_used) && !r_rd_vld;
    assign w_shift_done = (w_is_insert ? (r_ptr == r_pos) : (r_ptr == r_used)) && !r_rd_vld;
    assign w_match = (r_rd_data.radius == r_rad) && (r_rd_data.distance == r_dist);
    assign w_gap = (r_rd_data.radius > r_size) ? (r_rd_data.radius - r_size)
                                               : (r_size - r_rd_data.radius);
    assign w_diff = w_sub_a - w_sub_b;
    assign w_abs = w_diff[DIFF_W-1] ? $unsigned(-w_diff) : $unsigned(w_diff);
    assign w_sq = PROD_W'(r_opnd) * PROD_W'(r_opnd);
    assign w_lim = {r_prod, LIM_SHIFT'(0)};

    assign s_axis_tready = r_state == ST_IDLE;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata = r_m_data;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (w_in_cmd)
                        CMD_INSERT: n_state = w_full ? ST_DONE : ST_SCAN;
                        CMD_REMOVE_INDEX: n_state = w_bad_idx ? ST_DONE : ST_SHIFT;
                        default: n_state = ST_SCAN;
                    endcase
                end
            end
            ST_SCAN: begin
                if (w_scan_done) begin
                    case (r_cmd)
                        CMD_INSERT: n_state = ST_SHIFT;
                        CMD_REMOVE_PAIR: n_state = r_found ? ST_SHIFT : ST_DONE;
                        CMD_QUERY: n_state = (!r_picked || r_best_dist == '0) ? ST_DONE
                                                                              : ST_MATH;
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_SHIFT: begin
                if (w_shift_done) begin
                    n_state = w_is_insert ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE: n_state = ST_DONE;
            ST_MATH: begin
                if (r_step == STEP_CMP) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory port and shared subtractor controls
    always_comb begin
        w_mem_re = 1'b0;
        w_mem_we = 1'b0;
        w_rd_src = r_ptr;
        w_wr_dst = r_pos;
        w_wdata = r_rd_data;
        w_sub_a = '0;
        w_sub_b = '0;
        case (r_state)
            ST_SCAN: w_mem_re = r_ptr < r_used;
            ST_SHIFT: begin
                if (w_is_insert) begin
                    w_mem_re = r_ptr > r_pos;
                    w_rd_src = r_ptr - CNT_ONE;
                    w_wr_dst = r_rd_idx + CNT_ONE;
                end else begin
                    w_mem_re = r_ptr < r_used;
                    w_wr_dst = r_rd_idx - CNT_ONE;
                end
                w_mem_we = r_rd_vld;
            end
            ST_WRITE: begin
                w_mem_we = 1'b1;
                w_wdata.radius = r_rad;
                w_wdata.distance = r_dist;
            end
            ST_MATH: begin
                case (r_step)
                    STEP_X: begin
                        w_sub_a = DIFF_W'(r_obj_x);
                        w_sub_b = DIFF_W'(r_cam_x);
                    end
                    STEP_Y: begin
                        w_sub_a = DIFF_W'(r_obj_y);
                        w_sub_b = DIFF_W'(r_cam_y);
                    end
                    STEP_Z: begin
                        w_sub_a = DIFF_W'(r_obj_z);
                        w_sub_b = DIFF_W'(r_cam_z);
                    end
                    STEP_DIST: w_sub_a = $signed({(DIFF_W - FIELD_W)'(0), r_best_dist});
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_dst[IDX_W-1:0]] <= w_wdata;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[w_rd_src[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used <= '0;
            r_rd_vld <= 1'b0;
            r_m_valid <= 1'b0;
            r_cam_x <= '0;
            r_cam_y <= '0;
            r_cam_z <= '0;
        end else begin
            r_state <= n_state;
            r_rd_vld <= w_mem_re;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CAMERA_X: r_cam_x <= i_cfg_data[COORD_WIDTH-1:0];
                    CFG_CAMERA_Y: r_cam_y <= i_cfg_data[COORD_WIDTH-1:0];
                    CFG_CAMERA_Z: r_cam_z <= i_cfg_data[COORD_WIDTH-1:0];
                    default: ;
                endcase
            end

            if (r_state == ST_DONE && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_cmd <= w_in_cmd;
                        r_rad <= s_axis_tdata[OFS_RADIUS +: FIELD_W];
                        r_dist <= s_axis_tdata[OFS_DIST +: FIELD_W];
                        r_obj_x <= s_axis_tdata[OFS_X +: COORD_WIDTH];
                        r_obj_y <= s_axis_tdata[OFS_Y +: COORD_WIDTH];
                        r_obj_z <= s_axis_tdata[OFS_Z +: COORD_WIDTH];
                        r_size <= s_axis_tdata[OFS_SIZE +: FIELD_W];
                        r_found <= 1'b0;
                        r_picked <= 1'b0;
                        r_vis <= 1'b0;
                        if (w_in_cmd == CMD_INSERT && w_full) begin
                            r_status <= STAT_FULL;
                        end else if (w_in_cmd == CMD_REMOVE_INDEX && w_bad_idx) begin
                            r_status <= STAT_BAD_INDEX;
                        end else begin
                            r_status <= STAT_OK;
                        end
                        if (w_in_cmd == CMD_REMOVE_INDEX && !w_bad_idx) begin
                            r_pos <= CNT_W'(w_in_idx);
                            r_ptr <= CNT_W'(w_in_idx) + CNT_ONE;
                        end else begin
                            r_pos <= '0;
                            r_ptr <= '0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (w_mem_re) begin
                        r_ptr <= r_ptr + CNT_ONE;
                        r_rd_idx <= r_ptr;
                    end
                    if (r_rd_vld) begin
                        case (r_cmd)
                            CMD_INSERT: begin
                                if (r_rd_data.radius > r_rad) begin
                                    r_pos <= r_rd_idx + CNT_ONE;
                                end
                            end
                            CMD_REMOVE_PAIR: begin
                                if (!r_found && w_match) begin
                                    r_found <= 1'b1;
                                    r_pos <= r_rd_idx;
                                end
                            end
                            CMD_QUERY: begin
                                if (!r_picked || w_gap < r_best_gap) begin
                                    r_picked <= 1'b1;
                                    r_best_gap <= w_gap;
                                    r_best_dist <= r_rd_data.distance;
                                end
                            end
                            default: ;
                        endcase
                    end
                    if (w_scan_done) begin
                        case (r_cmd)
                            CMD_INSERT: r_ptr <= r_used;
                            CMD_REMOVE_PAIR: begin
                                if (r_found) begin
                                    r_ptr <= r_pos + CNT_ONE;
                                end else begin
                                    r_status <= STAT_NO_MATCH;
                                end
                            end
                            CMD_QUERY: begin
                                if (!r_picked || r_best_dist == '0) begin
                                    r_vis <= 1'b1;
                                end
                                r_step <= STEP_X;
                                r_acc <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SHIFT: begin
                    if (w_mem_re) begin
                        r_rd_idx <= w_rd_src;
                        r_ptr <= w_is_insert ? (r_ptr - CNT_ONE) : (r_ptr + CNT_ONE);
                    end
                    if (w_shift_done && !w_is_insert) begin
                        r_used <= r_used - CNT_ONE;
                    end
                end
                ST_WRITE: r_used <= r_used + CNT_ONE;
                ST_MATH: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step <= STEP_DIST) begin
                        r_opnd <= w_abs;
                    end
                    if (r_step >= STEP_Y && r_step <= STEP_LAST_SQ) begin
                        r_prod <= w_sq;
                    end
                    if (r_step >= STEP_Z && r_step <= STEP_LAST_SQ) begin
                        r_acc <= r_acc + ACC_W'(r_prod);
                    end
                    if (r_step == STEP_CMP) begin
                        r_vis <= CMP_W'(r_acc) < w_lim;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_m_data <= OUT_TDATA_W'({ENTRY_COUNT_W'(r_used), r_status, r_vis});
                    end
                end
                default: ;
            endcase
        end
    end

    // table never overfills
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_DEPTH)
        else $error("entry count above table depth");

    // read data always belongs to a live entry
    a_read_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_rd_idx < r_used))
        else $error("table read beyond held entries");

    // a new result only follows the done state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state) == ST_DONE)
        else $error("result raised outside done state");

    // distance sum starts from zero
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MATH && r_step == STEP_X) |-> r_acc == '0)
        else $error("distance accumulator not cleared");

endmodule

`default_nettype wire

@@ dv/tb_size_class_distance_culler_top.sv @@
// self-checking testbench for the size class distance culler top level
`timescale 1ns / 1ps

module tb_size_class_distance_culler_top;

    import scdc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 600;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 250;

    typedef struct packed {
        t_cmd                     cmd;
        logic [FIELD_W-1:0]       radius;
        logic [FIELD_W-1:0]       distance;
        logic [ENTRY_INDEX_W-1:0] index;
        logic [COORD_WIDTH-1:0]   obj_x;
        logic [COORD_WIDTH-1:0]   obj_y;
        logic [COORD_WIDTH-1:0]   obj_z;
        logic [FIELD_W-1:0]       size;
    } t_cull_item;

    typedef struct packed {
        logic                     visible;
        t_status                  status;
        logic [ENTRY_COUNT_W-1:0] count;
    } t_cull_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic [CFG_INDEX_W-1:0]   i_cfg_index = '0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_TDATA_W-1:0]    s_axis_tdata = '0;
    logic [CMD_W-1:0]         s_axis_tuser = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;

    size_class_distance_culler_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // size class table as the block should hold it
    logic [FIELD_W-1:0]     class_radius [TABLE_DEPTH];
    logic [FIELD_W-1:0]     class_distance [TABLE_DEPTH];
    int unsigned            class_count = 0;
    logic [COORD_WIDTH-1:0] camera_pos [3] = '{default: '0};

    t_cull_item   pending_items [$];
    t_cull_result awaited_results [$];
    t_cull_item   driven_item;
    logic         item_taken = 1'b0;
    int unsigned  fail_count = 0;
    int unsigned  cycle_count = 0;
    int unsigned  hold_requests = 0;
    int unsigned  holds_served = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void erase_class(int unsigned pos);
        int unsigned i;
        for (i = pos; i + 1 < class_count; i++) begin
            class_radius[i] = class_radius[i + 1];
            class_distance[i] = class_distance[i + 1];
        end
        class_count--;
    endfunction

    function automatic t_cull_result predict_culler_result(t_cull_item it);
        t_cull_result res;
        int unsigned i;
        int unsigned pos;
        int unsigned gap;
        int unsigned best_gap;
        logic [FIELD_W-1:0] best_dist;
        bit found;
        logic [COORD_WIDTH-1:0] obj [3];
        longint delta;
        longint sq_sum;
        longint limit;
        res.visible = 1'b0;
        res.status = STAT_OK;
        case (it.cmd)
            CMD_INSERT: begin
                if (class_count >= TABLE_DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    pos = 0;
                    for (i = 0; i < class_count; i++)
                        if (class_radius[i] > it.radius) pos = i + 1;
                    for (i = class_count; i > pos; i--) begin
                        class_radius[i] = class_radius[i - 1];
                        class_distance[i] = class_distance[i - 1];
                    end
                    class_radius[pos] = it.radius;
                    class_distance[pos] = it.distance;
                    class_count++;
                end
            end
            CMD_REMOVE_PAIR: begin
                found = 1'b0;
                pos = 0;
                for (i = 0; i < class_count && !found; i++) begin
                    if (class_radius[i] == it.radius && class_distance[i] == it.distance) begin
                        found = 1'b1;
                        pos = i;
                    end
                end
                if (found) erase_class(pos);
                else res.status = STAT_NO_MATCH;
            end
            CMD_REMOVE_INDEX: begin
                if (it.index >= class_count) res.status = STAT_BAD_INDEX;
                else erase_class(it.index);
            end
            default: begin
                found = 1'b0;
                best_gap = 0;
                best_dist = '0;
                for (i = 0; i < class_count; i++) begin
                    gap = (class_radius[i] > it.size) ? class_radius[i] - it.size
                                                      : it.size - class_radius[i];
                    if (!found || gap < best_gap) begin
                        found = 1'b1;
                        best_gap = gap;
                        best_dist = class_distance[i];
                    end
                end
                if (!found || best_dist == 0) begin
                    res.visible = 1'b1;
                end else begin
                    obj[0] = it.obj_x;
                    obj[1] = it.obj_y;
                    obj[2] = it.obj_z;
                    sq_sum = 0;
                    for (i = 0; i < 3; i++) begin
                        delta = longint'($signed(obj[i])) - longint'($signed(camera_pos[i]));
                        sq_sum += delta * delta;
                    end
                    limit = (longint'(best_dist) * longint'(best_dist)) << LIM_SHIFT;
                    res.visible = (sq_sum < limit);
                end
            end
        endcase
        res.count = ENTRY_COUNT_W'(class_count);
        return res;
    endfunction

    // unused fields get random content so that all their bits move
    function automatic t_cull_item make_item(t_cmd cmd, logic [FIELD_W-1:0] radius,
                                             logic [FIELD_W-1:0] distance,
                                             logic [ENTRY_INDEX_W-1:0] index,
                                             logic [FIELD_W-1:0] size,
                                             logic [COORD_WIDTH-1:0] x,
                                             logic [COORD_WIDTH-1:0] y,
                                             logic [COORD_WIDTH-1:0] z);
        t_cull_item it;
        it.cmd = cmd;
        it.radius = (cmd == CMD_INSERT || cmd == CMD_REMOVE_PAIR) ? radius : FIELD_W'($urandom);
        it.distance = (cmd == CMD_INSERT || cmd == CMD_REMOVE_PAIR) ? distance
                                                                     : FIELD_W'($urandom);
        it.index = (cmd == CMD_REMOVE_INDEX) ? index : ENTRY_INDEX_W'($urandom);
        it.size = (cmd == CMD_QUERY) ? size : FIELD_W'($urandom);
        it.obj_x = (cmd == CMD_QUERY) ? x : COORD_WIDTH'($urandom);
        it.obj_y = (cmd == CMD_QUERY) ? y : COORD_WIDTH'($urandom);
        it.obj_z = (cmd == CMD_QUERY) ? z : COORD_WIDTH'($urandom);
        return it;
    endfunction

    function automatic logic [FIELD_W-1:0] pick_radius();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd1;
            2, 3: return 16'd100;
            4: return 16'd1000;
            5: return 16'd30000;
            6: return 16'hFFFF;
            7: return 16'hFFFE;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] pick_distance();
        case ($urandom_range(0, 9))
            0, 1: return 16'd0;
            2: return 16'd1;
            3: return 16'd2;
            4: return 16'd100;
            5: return 16'd300;
            6: return 16'd1000;
            7: return 16'd30000;
            8: return 16'hFFFF;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    // object near the camera on a random scale, now and then anywhere
    function automatic logic [COORD_WIDTH-1:0] pick_coord(logic [COORD_WIDTH-1:0] cam);
        logic [COORD_WIDTH-1:0] offset;
        if ($urandom_range(0, 7) == 0) return COORD_WIDTH'($urandom);
        offset = COORD_WIDTH'($urandom_range(0, 1 << $urandom_range(0, COORD_WIDTH - 1)));
        if ($urandom_range(0, 1)) offset = -offset;
        return cam + offset;
    endfunction

    function automatic t_cull_item random_item(int unsigned insert_pct);
        int unsigned roll;
        int unsigned rest;
        t_cmd cmd;
        logic [FIELD_W-1:0] size;
        roll = $urandom_range(0, 99);
        rest = 100 - insert_pct;
        if (roll < insert_pct) cmd = CMD_INSERT;
        else if (roll < insert_pct + rest * 3 / 10) cmd = CMD_REMOVE_PAIR;
        else if (roll < insert_pct + rest * 55 / 100) cmd = CMD_REMOVE_INDEX;
        else cmd = CMD_QUERY;
        size = $urandom_range(0, 1) ? pick_radius() + FIELD_W'($urandom_range(0, 2)) - 16'd1
                                    : FIELD_W'($urandom);
        return make_item(cmd, pick_radius(), pick_distance(), ENTRY_INDEX_W'($urandom), size,
                         pick_coord(camera_pos[0]), pick_coord(camera_pos[1]),
                         pick_coord(camera_pos[2]));
    endfunction

    task automatic write_camera(input logic [CFG_INDEX_W-1:0] reg_index,
                                input logic [COORD_WIDTH-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= reg_index;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        camera_pos[reg_index] = value;
    endtask

    task automatic place_camera(input logic [COORD_WIDTH-1:0] x, input logic [COORD_WIDTH-1:0] y,
                                input logic [COORD_WIDTH-1:0] z);
        write_camera(CFG_CAMERA_X, x);
        write_camera(CFG_CAMERA_Y, y);
        write_camera(CFG_CAMERA_Z, z);
    endtask

    task automatic wait_until_drained();
        while (pending_items.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // sender: bursts of items with random gaps
    always @(negedge i_clk) begin : send_items
        logic [IN_TDATA_W-1:0] tdata;
        int unsigned burst_left;
        int unsigned gap_left;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else if (!s_axis_tvalid || item_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                driven_item = pending_items.pop_front();
                tdata = '0;
                tdata[OFS_RADIUS +: FIELD_W] = driven_item.radius;
                tdata[OFS_DIST +: FIELD_W] = driven_item.distance;
                tdata[OFS_INDEX +: ENTRY_INDEX_W] = driven_item.index;
                tdata[OFS_X +: COORD_WIDTH] = driven_item.obj_x;
                tdata[OFS_Y +: COORD_WIDTH] = driven_item.obj_y;
                tdata[OFS_Z +: COORD_WIDTH] = driven_item.obj_z;
                tdata[OFS_SIZE +: FIELD_W] = driven_item.size;
                s_axis_tdata <= tdata;
                s_axis_tuser <= driven_item.cmd;
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall rate changes from window to window, plus long hold-offs on request
    always @(negedge i_clk) begin : take_results
        int unsigned window_left;
        int unsigned stall_pct;
        int unsigned hold_left;
        if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = LONG_HOLD;
        end
        if (window_left == 0) begin
            window_left = $urandom_range(50, 300);
            case ($urandom_range(0, 4))
                0, 1: stall_pct = 0;
                2: stall_pct = 25;
                3: stall_pct = 60;
                default: stall_pct = 90;
            endcase
        end else begin
            window_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_cull_result got;
        t_cull_result want;
        if (!i_rst_n) begin
            item_taken <= 1'b0;
        end else begin
            item_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                awaited_results.push_back(predict_culler_result(driven_item));
            if (m_axis_tvalid && m_axis_tready) begin
                got.visible = m_axis_tdata[0];
                got.status = t_status'(m_axis_tdata[2:1]);
                got.count = m_axis_tdata[6:3];
                if (awaited_results.size() == 0) begin
                    $error("result item with no item pending");
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.visible !== want.visible) begin
                        $error("visible: expected %0d, actual %0d", want.visible, got.visible);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.count !== want.count) begin
                        $error("entry_count: expected %0d, actual %0d", want.count, got.count);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : run_phases
        int unsigned phase;
        int unsigned n;
        int unsigned insert_pct;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        place_camera(24'h000100, 24'hFFFE00, 24'h7FFFFF);
        // empty table cases
        pending_items.push_back(make_item(CMD_QUERY, 0, 0, 0, 16'd100, 24'h800000, 24'h7FFFFF, 0));
        pending_items.push_back(make_item(CMD_REMOVE_PAIR, 16'd5, 16'd5, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_REMOVE_INDEX, 0, 0, 3'd0, 0, 0, 0, 0));
        // fill the table, with equal radii and duplicates
        pending_items.push_back(make_item(CMD_INSERT, 16'd100, 16'd50, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_INSERT, 16'hFFFF, 16'd0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_INSERT, 16'd0, 16'hFFFF, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_INSERT, 16'd100, 16'd60, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_INSERT, 16'd200, 16'd10, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_INSERT, 16'd50, 16'd1, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_INSERT, 16'd100, 16'd50, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_INSERT, 16'd7, 16'd3, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_INSERT, 16'd9, 16'd9, 0, 0, 0, 0, 0));
        // tie on size 150 goes to the earlier entry, then just inside and on the limit
        pending_items.push_back(make_item(CMD_QUERY, 0, 0, 0, 16'd150,
                                          camera_pos[0] + 24'd2304, camera_pos[1],
                                          camera_pos[2]));
        pending_items.push_back(make_item(CMD_QUERY, 0, 0, 0, 16'd150,
                                          camera_pos[0] + 24'd2560, camera_pos[1],
                                          camera_pos[2]));
        // unlimited entry picked, then the largest distance at the far corner
        pending_items.push_back(make_item(CMD_QUERY, 0, 0, 0, 16'hFFFF,
                                          24'h800000, 24'h800000, 24'h800000));
        pending_items.push_back(make_item(CMD_QUERY, 0, 0, 0, 16'd0,
                                          24'h800000, 24'h7FFFFF, 24'h800000));
        pending_items.push_back(make_item(CMD_QUERY, 0, 0, 0, 16'd0,
                                          camera_pos[0] - 24'd5000, camera_pos[1] + 24'd5000,
                                          camera_pos[2]));
        // removes: first of two matches, unlimited by raw zero, a miss, index limits
        pending_items.push_back(make_item(CMD_REMOVE_PAIR, 16'd100, 16'd50, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_REMOVE_PAIR, 16'hFFFF, 16'd0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_REMOVE_PAIR, 16'd100, 16'd99, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_REMOVE_INDEX, 0, 0, 3'd7, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_REMOVE_INDEX, 0, 0, 3'd5, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_REMOVE_INDEX, 0, 0, 3'd0, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_QUERY, 0, 0, 0, 16'd100,
                                          24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));

        for (phase = 0; phase < PHASES; phase++) begin
            wait_until_drained();
            case (phase)
                0: place_camera(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
                1: place_camera(24'h800000, 24'h800000, 24'h800000);
                2: place_camera(24'h000000, 24'h000000, 24'h000000);
                default: place_camera(COORD_WIDTH'($urandom), COORD_WIDTH'($urandom),
                                      COORD_WIDTH'($urandom));
            endcase
            insert_pct = (phase % 2 == 0) ? 55 : 38;
            for (n = 0; n < PHASE_ITEMS; n++)
                pending_items.push_back(random_item(insert_pct));
            if (phase == 1 || phase == 4) hold_requests++;
        end

        wait_until_drained();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && awaited_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/scdc_pkg.sv
sv/size_class_distance_culler_top.sv
dv/tb_size_class_distance_culler_top.sv
